// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the crsf receiver modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled while in reset
`define CRSF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("crsf assertion failed");
// next-cycle implication, disabled while in reset
`define CRSF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("crsf assertion failed");
`else
`define CRSF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CRSF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: src/crsf_pkg.sv
// ----------------------------------------------------------------------------
// crsf_pkg
// shared types and status codes of the crsf frame receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crsf_pkg;

    typedef logic [2:0] t_status;

    localparam t_status ST_IN_FRAME      = 3'd0;
    localparam t_status ST_ADDR_MISMATCH = 3'd1;
    localparam t_status ST_BAD_LENGTH    = 3'd2;
    localparam t_status ST_FRAME_OK      = 3'd3;
    localparam t_status ST_CRC_ERROR     = 3'd4;
    localparam t_status ST_TIMEOUT       = 3'd5;

    localparam logic [7:0] SYNC_RESET = 8'd200;

    typedef struct packed {
        t_status    status;
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic [7:0] frame_type;
    } t_result;

endpackage

// File: src/crsf_if.sv
// ----------------------------------------------------------------------------
// crsf_if
// valid/ready channels of the crsf frame receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface crsf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       is_timeout;

    modport source (output valid, rx_byte, is_timeout, input ready);
    modport sink   (input valid, rx_byte, is_timeout, output ready);
endinterface

interface crsf_res_if;
    logic                valid;
    logic                ready;
    crsf_pkg::t_status   status;
    logic [7:0]          data_byte;
    logic [5:0]          byte_index;
    logic [7:0]          frame_type;

    modport source (output valid, status, data_byte, byte_index, frame_type, input ready);
    modport sink   (input valid, status, data_byte, byte_index, frame_type, output ready);
endinterface

interface crsf_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: src/crsf_crc8.sv
// ----------------------------------------------------------------------------
// crsf_crc8
// one byte step of crc-8 dvb-s2 (poly 0xd5, msb first)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crsf_crc8 (
    input  logic [7:0] i_crc,
    input  logic [7:0] i_data,
    output logic [7:0] o_crc
);

    localparam logic [7:0] CrcPoly = 8'hD5;

    always_comb begin
        logic [7:0] c;
        c = i_crc ^ i_data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

// File: src/crsf_deframer.sv
// ----------------------------------------------------------------------------
// crsf_deframer
// frame position tracking, length check and running crc per byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crsf_deframer #(
    parameter int MAX_FRAME = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_is_timeout,
    input  logic [7:0]        i_sync_address,
    output crsf_pkg::t_result o_result
);

    localparam int         CntW   = $clog2(MAX_FRAME);
    localparam logic [7:0] MinLen = 8'd2;
    localparam logic [7:0] MaxLen = 8'(MAX_FRAME - 2);

    logic [CntW-1:0] r_byte_count, n_byte_count;
    logic [7:0]      r_frame_length, n_frame_length;
    logic [7:0]      r_running_crc, n_running_crc;
    logic [7:0]      r_type_byte, n_type_byte;

    logic [7:0]      crc_next;
    logic [8:0]      count_ext;
    logic [8:0]      len_end;
    logic [CntW+5:0] idx_ext;

    crsf_crc8 u_crc (
        .i_crc  (r_running_crc),
        .i_data (i_rx_byte),
        .o_crc  (crc_next)
    );

    assign count_ext = 9'(r_byte_count);
    assign len_end   = {1'b0, r_frame_length} + 9'd1;
    assign idx_ext   = {6'd0, r_byte_count};

    always_comb begin
        n_byte_count        = r_byte_count;
        n_frame_length      = r_frame_length;
        n_running_crc       = r_running_crc;
        n_type_byte         = r_type_byte;
        o_result.status     = crsf_pkg::ST_IN_FRAME;
        o_result.data_byte  = i_rx_byte;
        o_result.byte_index = idx_ext[5:0];
        o_result.frame_type = 8'd0;

        if (i_is_timeout) begin
            // partial frame is kept as it is
            o_result.status     = crsf_pkg::ST_TIMEOUT;
            o_result.data_byte  = 8'd0;
            o_result.frame_type = r_type_byte;
        end else if (r_byte_count == '0) begin
            if (i_rx_byte != i_sync_address) begin
                o_result.status = crsf_pkg::ST_ADDR_MISMATCH;
            end else begin
                n_byte_count  = CntW'(1);
                n_running_crc = 8'd0;
                n_type_byte   = 8'd0;
            end
        end else if (count_ext == 9'd1) begin
            if (i_rx_byte < MinLen || i_rx_byte > MaxLen) begin
                o_result.status = crsf_pkg::ST_BAD_LENGTH;
                n_byte_count    = '0;
            end else begin
                n_frame_length = i_rx_byte;
                n_byte_count   = CntW'(2);
            end
        end else if (count_ext == len_end) begin
            o_result.status     = (i_rx_byte == r_running_crc) ?
                                  crsf_pkg::ST_FRAME_OK : crsf_pkg::ST_CRC_ERROR;
            o_result.frame_type = r_type_byte;
            n_byte_count        = '0;
        end else begin
            // type byte or payload byte
            if (count_ext == 9'd2) begin
                n_type_byte = i_rx_byte;
            end
            o_result.frame_type = n_type_byte;
            n_running_crc       = crc_next;
            n_byte_count        = r_byte_count + CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_frame_length <= 8'd0;
            r_running_crc  <= 8'd0;
            r_type_byte    <= 8'd0;
        end else if (i_accept) begin
            r_byte_count   <= n_byte_count;
            r_frame_length <= n_frame_length;
            r_running_crc  <= n_running_crc;
            r_type_byte    <= n_type_byte;
        end
    end

    `CRSF_ASSERT_NXT(a_restart_after_end, i_clk, i_rst_n, i_accept && !i_is_timeout && (o_result.status == crsf_pkg::ST_FRAME_OK || o_result.status == crsf_pkg::ST_CRC_ERROR || o_result.status == crsf_pkg::ST_BAD_LENGTH), r_byte_count == '0)
    `CRSF_ASSERT_NXT(a_timeout_keeps_frame, i_clk, i_rst_n, i_accept && i_is_timeout, $stable(r_byte_count) && $stable(r_running_crc) && $stable(r_type_byte))
    `CRSF_ASSERT_IMP(a_count_in_frame, i_clk, i_rst_n, count_ext > 9'd1, count_ext <= len_end)

endmodule

// File: src/crsf_out_stage.sv
// ----------------------------------------------------------------------------
// crsf_out_stage
// result register between the deframer and the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crsf_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  crsf_pkg::t_result i_result,
    output logic              o_ready,
    crsf_res_if.source        o_res
);

    logic              r_valid;
    crsf_pkg::t_result r_result;

    // a new result may enter when the register is empty or being drained
    assign o_ready = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.status     = r_result.status;
    assign o_res.data_byte  = r_result.data_byte;
    assign o_res.byte_index = r_result.byte_index;
    assign o_res.frame_type = r_result.frame_type;

endmodule

// File: src/crsf_frame_receiver.sv
// ----------------------------------------------------------------------------
// crsf_frame_receiver
// byte-serial crsf deframer with crc-8 dvb-s2 check
// ----------------------------------------------------------------------------
// Takes one received byte (or a timeout marker) per transaction and returns
// exactly one status transaction for it from the output register. A byte
// can be accepted on every clock: the frame counter, length and crc state
// are updated in the same cycle the byte is taken, and the result sits in a
// single output register that is refilled in the cycle it is drained, so the
// sustained rate is one byte per cycle as long as the result side keeps up.
// The sync address register resets to 200 and should be written only while
// no result is outstanding.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crsf_frame_receiver #(
    parameter int MAX_FRAME = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    crsf_rx_if.sink    i_rx,
    crsf_res_if.source o_res,
    crsf_cfg_if.sink   i_cfg
);

    logic [7:0]        r_sync_address;
    logic              rx_ready;
    logic              rx_accept;
    crsf_pkg::t_result result;

    assign i_cfg.ready = 1'b1;
    assign i_rx.ready  = rx_ready;
    assign rx_accept   = i_rx.valid && rx_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_address <= crsf_pkg::SYNC_RESET;
        end else if (i_cfg.valid) begin
            r_sync_address <= i_cfg.data;
        end
    end

    crsf_deframer #(
        .MAX_FRAME (MAX_FRAME)
    ) u_deframer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (rx_accept),
        .i_rx_byte      (i_rx.rx_byte),
        .i_is_timeout   (i_rx.is_timeout),
        .i_sync_address (r_sync_address),
        .o_result       (result)
    );

    crsf_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (rx_accept),
        .i_result (result),
        .o_ready  (rx_ready),
        .o_res    (o_res)
    );

    `CRSF_ASSERT_NXT(a_accept_gives_result, i_clk, i_rst_n, rx_accept, o_res.valid)

endmodule
